// ===== hw/rtl/tlla_pkg.sv =====
package tlla_pkg;

   localparam int DEF_POINTS = 256;

   localparam int SAMPLE_W = 24;
   localparam int CFG_W    = 21;
   localparam int LIM_W    = 25;   // limit times ten, full 21-bit range
   localparam int ID_W     = 16;
   localparam int TAG_W    = 8;
   localparam int LEVELS   = 3;
   localparam int SLOT_W   = 2 * LEVELS;

   // slot codes
   localparam logic [1:0] SLOT_IDLE = 2'd0;
   localparam logic [1:0] SLOT_HIGH = 2'd1;
   localparam logic [1:0] SLOT_LOW  = 2'd2;

   // event kinds
   localparam logic [1:0] KIND_END        = 2'd0;
   localparam logic [1:0] KIND_HIGH_START = 2'd1;
   localparam logic [1:0] KIND_LOW_START  = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_ENABLE     = 3'd0;
   localparam logic [2:0] CSR_HIGH_ONE   = 3'd1;
   localparam logic [2:0] CSR_HIGH_TWO   = 3'd2;
   localparam logic [2:0] CSR_HIGH_THREE = 3'd3;
   localparam logic [2:0] CSR_LOW_ONE    = 3'd4;
   localparam logic [2:0] CSR_LOW_TWO    = 3'd5;
   localparam logic [2:0] CSR_LOW_THREE  = 3'd6;

   localparam logic [LIM_W-1:0] LIM_HIGH_RST = LIM_W'(8388600);
   localparam logic [LIM_W-1:0] LIM_LOW_RST  = LIM_W'(-8388600);

   typedef logic [LEVELS-1:0][LIM_W-1:0] lim_arr_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [TAG_W-1:0]           device_tag;
      logic [TAG_W-1:0]           point_index;
      logic [ID_W-1:0]            low_alarm_id;
      logic [ID_W-1:0]            high_alarm_id;
   } req_type;

   typedef struct packed {
      logic                       is_event;
      logic [ID_W-1:0]            event_id;
      logic [1:0]                 event_kind;
      logic [1:0]                 event_level;
      logic                       event_is_low;
      logic [TAG_W-1:0]           out_device;
      logic [TAG_W-1:0]           out_point;
      logic signed [SAMPLE_W-1:0] out_sample;
      logic [1:0]                 active_level;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic [LEVELS-1:0] hi_ev;
      logic [LEVELS-1:0] hi_start;
      logic [LEVELS-1:0] lo_ev;
      logic [LEVELS-1:0] lo_start;
      logic [SLOT_W-1:0] new_slots;
      logic [1:0]        status;
      logic              wr_en;
   } eval_type;

   function automatic logic [LIM_W-1:0] scale_limit(input logic [CFG_W-1:0] v);
      logic signed [LIM_W-1:0] x;
      x = LIM_W'($signed(v));
      return LIM_W'((x <<< 3) + (x <<< 1));
   endfunction

endpackage

// ===== hw/rtl/tlla_eval.sv =====
module tlla_eval (
   input  logic signed [tlla_pkg::SAMPLE_W-1:0] sample,
   input  logic [tlla_pkg::SLOT_W-1:0]          slots,
   input  logic                                 enable,
   input  logic                                 in_range,
   input  tlla_pkg::lim_arr_type                hi_lim,
   input  tlla_pkg::lim_arr_type                lo_lim,
   output tlla_pkg::eval_type                   ev
);
   import tlla_pkg::*;

   logic signed [LIM_W-1:0]  sx;
   logic [LEVELS-1:0][1:0]   slot;
   logic                     found;

   assign sx = LIM_W'(sample);

   always_comb begin
      slot  = slots;
      ev    = '0;
      found = 1'b0;
      if (enable && in_range) begin
         // high side first, stop at the first level that is exceeded
         for (int lv = 0; lv < LEVELS; lv++) begin
            if (!found) begin
               if (sx > $signed(hi_lim[lv])) begin
                  found = 1'b1;
                  if (slot[lv] == SLOT_IDLE) begin
                     ev.hi_ev[lv]    = 1'b1;
                     ev.hi_start[lv] = 1'b1;
                     slot[lv]        = SLOT_HIGH;
                  end
               end else if (slot[lv] == SLOT_HIGH) begin
                  ev.hi_ev[lv] = 1'b1;
                  slot[lv]     = SLOT_IDLE;
               end
            end
         end
         found = 1'b0;
         for (int lv = 0; lv < LEVELS; lv++) begin
            if (!found) begin
               if (sx < $signed(lo_lim[lv])) begin
                  found = 1'b1;
                  if (slot[lv] == SLOT_IDLE) begin
                     ev.lo_ev[lv]    = 1'b1;
                     ev.lo_start[lv] = 1'b1;
                     slot[lv]        = SLOT_LOW;
                  end
               end else if (slot[lv] == SLOT_LOW) begin
                  ev.lo_ev[lv] = 1'b1;
                  slot[lv]     = SLOT_IDLE;
               end
            end
         end
      end
      ev.new_slots = slot;
      ev.wr_en     = enable && in_range;
      if (!in_range) begin
         ev.status = 2'd0;
      end else if (slot[0] != SLOT_IDLE) begin
         ev.status = 2'd1;
      end else if (slot[1] != SLOT_IDLE) begin
         ev.status = 2'd2;
      end else if (slot[2] != SLOT_IDLE) begin
         ev.status = 2'd3;
      end else begin
         ev.status = 2'd0;
      end
   end

endmodule

// ===== hw/rtl/three_level_limit_alarm.sv =====
// Three-level high/low limit alarm over a table of points.
// Request channel (req_valid/req_stall/req_data) carries one sample with its
// device tag, point index and the two alarm ids. Response channel
// (rsp_valid/rsp_stall/rsp_data) returns, per request, zero to six event
// items (high side levels 1..3, then low side levels 1..3) followed by one
// status item flagged by last.
// An accepted request goes into the evaluate stage (slot table read at the accepting
// edge, then evaluate and write back) and from there into the emit stage that drives the response.
// A request occupies the response side for its event items and its status item;
// with no events and no stall one request is taken every cycle.
// The per-point slot table is a single-port-write, single-read memory;
// a back-to-back request to the same point gets the fresh slots forwarded.
// Configuration is written through csr_we/csr_idx/csr_wdata; the user must do this
// only while idle, as the block does not enforce it. Reset clears the configuration
// to its defaults and starts a clearing pass over all POINTS entries of the slot
// table; req_stall stays high until it ends. While rsp_stall is high the shown
// response holds; one more request can wait in the evaluate stage, after which req_stall rises.
module three_level_limit_alarm #(
   parameter int POINTS = tlla_pkg::DEF_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tlla_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tlla_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_idx,
   input  logic [tlla_pkg::CFG_W-1:0]    csr_wdata
);
   import tlla_pkg::*;

   localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(POINTS - 1);

   // configuration
   logic         enable_ff;
   lim_arr_type  hi_lim_ff;
   lim_arr_type  lo_lim_ff;

   // clearing pass
   logic          clr_busy_ff;
   logic [AW-1:0] clr_cnt_ff;

   // slot table
   logic [SLOT_W-1:0] slot_mem [POINTS];
   logic [SLOT_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;

   // evaluate stage
   logic              req_accept;
   logic [AW-1:0]     req_addr;
   logic              req_inrange;
   logic              s1_vld_ff;
   req_type           s1_req_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              s1_inrange_ff;
   logic              fwd_hit_ff;
   logic [SLOT_W-1:0] fwd_data_ff;
   logic [SLOT_W-1:0] s1_slots;
   logic              s1_adv;
   eval_type          ev;

   // emit stage
   logic              em_vld_ff;
   req_type           em_req_ff;
   logic [LEVELS-1:0] em_hi_ev_ff;
   logic [LEVELS-1:0] em_hi_start_ff;
   logic [LEVELS-1:0] em_lo_ev_ff;
   logic [LEVELS-1:0] em_lo_start_ff;
   logic [1:0]        em_status_ff;
   logic [LEVELS-1:0] hi_oh;
   logic [LEVELS-1:0] lo_oh;
   logic              rsp_accept;
   logic              em_done;

   assign req_accept  = req_valid && !req_stall;
   assign req_addr    = AW'(req_data.point_index);
   assign req_inrange = 32'(req_data.point_index) < 32'(POINTS);
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign em_done     = rsp_accept && rsp_data.last;
   assign s1_adv      = s1_vld_ff && (!em_vld_ff || em_done);
   assign req_stall   = clr_busy_ff || (s1_vld_ff && !s1_adv);
   assign rsp_valid   = em_vld_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         hi_lim_ff <= {LEVELS{LIM_HIGH_RST}};
         lo_lim_ff <= {LEVELS{LIM_LOW_RST}};
      end else if (csr_we) begin
         case (csr_idx)
            CSR_ENABLE:     enable_ff    <= csr_wdata[0];
            CSR_HIGH_ONE:   hi_lim_ff[0] <= scale_limit(csr_wdata);
            CSR_HIGH_TWO:   hi_lim_ff[1] <= scale_limit(csr_wdata);
            CSR_HIGH_THREE: hi_lim_ff[2] <= scale_limit(csr_wdata);
            CSR_LOW_ONE:    lo_lim_ff[0] <= scale_limit(csr_wdata);
            CSR_LOW_TWO:    lo_lim_ff[1] <= scale_limit(csr_wdata);
            CSR_LOW_THREE:  lo_lim_ff[2] <= scale_limit(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- clearing pass ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == LAST_ADDR) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------- slot table ----------------
   assign mem_we    = clr_busy_ff || (s1_adv && ev.wr_en);
   assign mem_waddr = clr_busy_ff ? clr_cnt_ff : s1_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : ev.new_slots;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_data_ff <= slot_mem[req_addr];
      end
   end

   // ---------------- evaluate stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_accept) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff     <= req_data;
         s1_addr_ff    <= req_addr;
         s1_inrange_ff <= req_inrange;
         // the read misses a write-back to the same point at this edge
         fwd_hit_ff    <= s1_adv && ev.wr_en && (s1_addr_ff == req_addr);
         fwd_data_ff   <= ev.new_slots;
      end
   end

   assign s1_slots = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   tlla_eval u_eval (
      .sample   (s1_req_ff.sample),
      .slots    (s1_slots),
      .enable   (enable_ff),
      .in_range (s1_inrange_ff),
      .hi_lim   (hi_lim_ff),
      .lo_lim   (lo_lim_ff),
      .ev       (ev)
   );

   // ---------------- emit stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         em_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         em_vld_ff <= 1'b1;
      end else if (em_done) begin
         em_vld_ff <= 1'b0;
      end
   end

   assign hi_oh = em_hi_ev_ff & (~em_hi_ev_ff + LEVELS'(1));
   assign lo_oh = em_lo_ev_ff & (~em_lo_ev_ff + LEVELS'(1));

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         em_req_ff      <= s1_req_ff;
         em_hi_ev_ff    <= ev.hi_ev;
         em_hi_start_ff <= ev.hi_start;
         em_lo_ev_ff    <= ev.lo_ev;
         em_lo_start_ff <= ev.lo_start;
         em_status_ff   <= ev.status;
      end else if (rsp_accept) begin
         // drop the event just delivered
         if (|em_hi_ev_ff) begin
            em_hi_ev_ff <= em_hi_ev_ff & ~hi_oh;
         end else begin
            em_lo_ev_ff <= em_lo_ev_ff & ~lo_oh;
         end
      end
   end

   always_comb begin
      rsp_data            = '0;
      rsp_data.out_device = em_req_ff.device_tag;
      rsp_data.out_point  = em_req_ff.point_index;
      rsp_data.out_sample = em_req_ff.sample;
      if (|em_hi_ev_ff) begin
         rsp_data.is_event    = 1'b1;
         rsp_data.event_id    = em_req_ff.high_alarm_id;
         rsp_data.event_kind  = (|(hi_oh & em_hi_start_ff)) ? KIND_HIGH_START : KIND_END;
         rsp_data.event_level = {hi_oh[2] | hi_oh[1], hi_oh[2] | hi_oh[0]};
      end else if (|em_lo_ev_ff) begin
         rsp_data.is_event     = 1'b1;
         rsp_data.event_id     = em_req_ff.low_alarm_id;
         rsp_data.event_kind   = (|(lo_oh & em_lo_start_ff)) ? KIND_LOW_START : KIND_END;
         rsp_data.event_level  = {lo_oh[2] | lo_oh[1], lo_oh[2] | lo_oh[0]};
         rsp_data.event_is_low = 1'b1;
      end else begin
         rsp_data.active_level = em_status_ff;
         rsp_data.last         = 1'b1;
      end
   end

   // ---------------- assertions ----------------
   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_accept)
      else $error("request accepted during clearing pass");

   a_event_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_event |-> enable_ff)
      else $error("event emitted while checking disabled");

   a_no_write_out_of_range: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_inrange_ff |-> !mem_we)
      else $error("slot table written for point beyond table");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_adv |=> s1_vld_ff && $stable(s1_req_ff))
      else $error("evaluate stage lost its request");

endmodule

// ===== tb/sv/three_level_limit_alarm_tb.sv =====
module three_level_limit_alarm_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tlla_pkg::*;

   localparam int         NUM_POINTS = DEF_POINTS;
   localparam logic [2:0] CSR_SPARE  = 3'd7;   // index past the register list

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [2:0]           csr_idx   = CSR_ENABLE;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // alarm state as the block should hold it
   logic [1:0]           slot_tbl [NUM_POINTS][LEVELS];
   logic                 alarm_on;
   int                   cfg_high [LEVELS];
   int                   cfg_low  [LEVELS];

   req_type              samples_to_send [$];
   rsp_type              alarm_items_due [$];
   int                   mismatch_cnt  = 0;
   int                   req_idle_pct  = 37;
   int                   rsp_stall_pct = 37;

   three_level_limit_alarm i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void push_alarm_event(rsp_type base, logic [ID_W-1:0] id,
                                            logic [1:0] kind, int level, logic is_low);
      rsp_type ev;
      ev              = base;
      ev.is_event     = 1'b1;
      ev.event_id     = id;
      ev.event_kind   = kind;
      ev.event_level  = level[1:0];
      ev.event_is_low = is_low;
      alarm_items_due.push_back(ev);
   endfunction

   // Work out the events and the status item one accepted request causes.
   function automatic void predict_alarm(req_type r);
      rsp_type base;
      int      smp;
      int      pt;
      int      lv;
      logic    done;
      base             = '0;
      base.out_device  = r.device_tag;
      base.out_point   = r.point_index;
      base.out_sample  = r.sample;
      smp              = int'(r.sample);
      pt               = int'(r.point_index);
      if (pt < NUM_POINTS) begin
         if (alarm_on) begin
            done = 1'b0;
            for (lv = 0; lv < LEVELS; lv++) begin
               if (!done) begin
                  if (smp > cfg_high[lv] * 10) begin
                     if (slot_tbl[pt][lv] == SLOT_IDLE) begin
                        push_alarm_event(base, r.high_alarm_id, KIND_HIGH_START, lv + 1, 1'b0);
                        slot_tbl[pt][lv] = SLOT_HIGH;
                     end
                     done = 1'b1;
                  end else if (slot_tbl[pt][lv] == SLOT_HIGH) begin
                     push_alarm_event(base, r.high_alarm_id, KIND_END, lv + 1, 1'b0);
                     slot_tbl[pt][lv] = SLOT_IDLE;
                  end
               end
            end
            done = 1'b0;
            for (lv = 0; lv < LEVELS; lv++) begin
               if (!done) begin
                  if (smp < cfg_low[lv] * 10) begin
                     if (slot_tbl[pt][lv] == SLOT_IDLE) begin
                        push_alarm_event(base, r.low_alarm_id, KIND_LOW_START, lv + 1, 1'b1);
                        slot_tbl[pt][lv] = SLOT_LOW;
                     end
                     done = 1'b1;
                  end else if (slot_tbl[pt][lv] == SLOT_LOW) begin
                     push_alarm_event(base, r.low_alarm_id, KIND_END, lv + 1, 1'b1);
                     slot_tbl[pt][lv] = SLOT_IDLE;
                  end
               end
            end
         end
         if (slot_tbl[pt][0] != SLOT_IDLE) begin
            base.active_level = 2'd1;
         end else if (slot_tbl[pt][1] != SLOT_IDLE) begin
            base.active_level = 2'd2;
         end else if (slot_tbl[pt][2] != SLOT_IDLE) begin
            base.active_level = 2'd3;
         end
      end
      base.last = 1'b1;
      alarm_items_due.push_back(base);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatch_cnt++;
      end
   endfunction

   // request driver: hold the payload until taken, idle at random
   always @(posedge clock) begin : drive_req
      logic fire;
      fire = req_valid && !req_stall;
      if (fire) begin
         predict_alarm(req_data);
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || fire) begin
         if (samples_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            req_data  <= samples_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (alarm_items_due.size() == 0) begin
               $display("%0t: expected no response got %h", $time, rsp_data);
               mismatch_cnt++;
            end else begin
               want = alarm_items_due.pop_front();
               check_field("is_event", want.is_event, rsp_data.is_event);
               check_field("event_id", want.event_id, rsp_data.event_id);
               check_field("event_kind", want.event_kind, rsp_data.event_kind);
               check_field("event_level", want.event_level, rsp_data.event_level);
               check_field("event_is_low", want.event_is_low, rsp_data.event_is_low);
               check_field("out_device", want.out_device, rsp_data.out_device);
               check_field("out_point", want.out_point, rsp_data.out_point);
               check_field("out_sample", want.out_sample, rsp_data.out_sample);
               check_field("active_level", want.active_level, rsp_data.active_level);
               check_field("last", want.last, rsp_data.last);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ENABLE:                                 alarm_on = val[0];
         CSR_HIGH_ONE, CSR_HIGH_TWO, CSR_HIGH_THREE: cfg_high[idx - CSR_HIGH_ONE] = int'($signed(val));
         CSR_LOW_ONE, CSR_LOW_TWO, CSR_LOW_THREE:    cfg_low[idx - CSR_LOW_ONE] = int'($signed(val));
         default: ;   // no register behind this index
      endcase
   endtask

   task automatic set_limits(int h1, int h2, int h3, int l1, int l2, int l3);
      write_csr(CSR_HIGH_ONE, h1[CFG_W-1:0]);
      write_csr(CSR_HIGH_TWO, h2[CFG_W-1:0]);
      write_csr(CSR_HIGH_THREE, h3[CFG_W-1:0]);
      write_csr(CSR_LOW_ONE, l1[CFG_W-1:0]);
      write_csr(CSR_LOW_TWO, l2[CFG_W-1:0]);
      write_csr(CSR_LOW_THREE, l3[CFG_W-1:0]);
   endtask

   task automatic wait_idle();
      while (samples_to_send.size() != 0 || req_valid || alarm_items_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_sample(int smp, int pt);
      req_type r;
      r.sample        = smp[SAMPLE_W-1:0];
      r.device_tag    = TAG_W'($urandom);
      r.point_index   = pt[TAG_W-1:0];
      r.low_alarm_id  = ID_W'($urandom);
      r.high_alarm_id = ID_W'($urandom);
      samples_to_send.push_back(r);
   endtask

   function automatic int rand_limit();
      return int'($urandom_range(1677720)) - 838860;
   endfunction

   // Mostly samples close to a threshold on a few points, so slots move.
   task automatic queue_random(int count);
      int n;
      int smp;
      int pt;
      int lv;
      for (n = 0; n < count; n++) begin
         lv = $urandom_range(LEVELS - 1);
         case ($urandom_range(9))
            0, 1:    smp = $urandom;
            2:       smp = 8388607;
            3:       smp = -8388608;
            default: begin
               smp = ($urandom_range(1) ? cfg_high[lv] : cfg_low[lv]) * 10
                     + int'($urandom_range(40)) - 20;
               if (smp > 8388607) smp = 8388607;
               if (smp < -8388608) smp = -8388608;
            end
         endcase
         pt = ($urandom_range(7) == 0) ? $urandom_range(NUM_POINTS - 1) : $urandom_range(7);
         queue_sample(smp, pt);
      end
   endtask

   initial begin
      foreach (slot_tbl[p, l]) slot_tbl[p][l] = SLOT_IDLE;
      alarm_on = 1'b0;
      foreach (cfg_high[l]) begin
         cfg_high[l] = 838860;
         cfg_low[l]  = -838860;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // hold off until the slot table clearing is done
      while (req_stall) @(posedge clock);

      // checking off after reset: status only
      queue_sample(8388607, 3);
      queue_sample(-8388608, 3);
      wait_idle();

      // reset limits, just inside the sample range
      write_csr(CSR_ENABLE, 21'd1);
      queue_sample(8388607, 3);
      queue_sample(-8388608, 3);
      wait_idle();

      set_limits(300000, 200000, 100000, -300000, -200000, -100000);
      queue_sample(8388607, 5);
      queue_sample(2500000, 5);
      queue_sample(0, 5);
      queue_sample(-8388608, 5);
      queue_sample(-1500000, 5);
      // slot three is low here; the high side must not take it over
      queue_sample(1500000, 5);
      queue_sample(3000001, 0);
      queue_sample(3000000, 0);
      queue_sample(-3000000, 255);
      wait_idle();

      // disable with upper bits set: slots keep their values
      write_csr(CSR_ENABLE, 21'h1FFFFE);
      queue_sample(8388607, 3);
      queue_sample(0, 0);
      queue_sample(0, 255);
      wait_idle();

      // limits at the ends of the 21-bit range, times ten past any sample
      write_csr(CSR_ENABLE, 21'd1);
      set_limits(1048575, 1048575, 1048575, -1048576, -1048576, -1048576);
      write_csr(CSR_SPARE, 21'h15A5A5);
      queue_sample(8388607, 3);
      queue_sample(-8388608, 0);
      queue_sample(0, 255);
      wait_idle();

      set_limits(300000, 200000, 100000, -300000, -200000, -100000);
      queue_random(120);
      wait_idle();

      // no idling on either side for this stretch
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      set_limits(rand_limit(), rand_limit(), rand_limit(),
                 rand_limit(), rand_limit(), rand_limit());
      queue_random(120);
      wait_idle();
      req_idle_pct  = 37;
      rsp_stall_pct = 37;

      set_limits(-838860, 0, 838860, 838860, 0, -838860);
      queue_random(60);
      wait_idle();
      write_csr(CSR_ENABLE, 21'd0);
      queue_random(40);
      wait_idle();

      write_csr(CSR_ENABLE, 21'd1);
      set_limits(rand_limit(), rand_limit(), rand_limit(),
                 rand_limit(), rand_limit(), rand_limit());
      queue_random(55);
      wait_idle();
      queue_random(55);
      wait_idle();
      repeat (20) @(posedge clock);

      if (mismatch_cnt == 0 && alarm_items_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
